// ===== rtl/gamepad_chord_turbo_decoder_defines.svh =====
// Assertion macros for the gamepad chord and turbo decoder; gctd_chord uses them.
`ifndef GAMEPAD_CHORD_TURBO_DECODER_DEFINES_SVH
`define GAMEPAD_CHORD_TURBO_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GCTD_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("gctd: property failed");
`define GCTD_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (conseq)) \
        else $error("gctd: follow-up check failed");
`else
`define GCTD_ASSERT(label, prop)
`define GCTD_ASSERT_NEXT(label, cond, conseq)
`endif
`endif

// ===== rtl/gctd_pkg.sv =====
// Shared constants, key bit positions and the decode record of the chord and turbo decoder.
package gctd_pkg;

    localparam int unsigned MASK_W = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned GAME_W = 8;
    localparam int unsigned NAV_W  = 6;
    localparam int unsigned ACT_W  = 7;

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned M_PAD_W   = M_TDATA_W - GAME_W - NAV_W - ACT_W;

    // Turbo half period in milliseconds; a value of zero behaves as one.
    localparam int unsigned TURBO_HALF_MS  = 50;
    localparam int unsigned TURBO_HALF_EFF = (TURBO_HALF_MS == 0) ? 1 : TURBO_HALF_MS;

    // Slot index = (d * TURBO_RECIP) >> TURBO_SHIFT, exact for every 32-bit d.
    localparam int unsigned TURBO_SHIFT = TIME_W + $clog2(TURBO_HALF_EFF);
    localparam int unsigned RECIP_W     = TIME_W + 1;
    localparam int unsigned HALF_W      = TIME_W / 2;
    localparam int unsigned PROD_W      = TIME_W + RECIP_W;
    localparam logic [RECIP_W-1:0] TURBO_RECIP = RECIP_W'(
        ((64'd1 << TURBO_SHIFT) + 64'(TURBO_HALF_EFF) - 64'd1) / 64'(TURBO_HALF_EFF));

    // Bit positions in the pressed mask.
    localparam int unsigned K_UP     = 0;
    localparam int unsigned K_LEFT   = 1;
    localparam int unsigned K_X      = 3;
    localparam int unsigned K_A      = 4;
    localparam int unsigned K_Y      = 5;
    localparam int unsigned K_B      = 6;
    localparam int unsigned K_R      = 9;
    localparam int unsigned K_START  = 10;
    localparam int unsigned K_SELECT = 12;
    localparam int unsigned K_L      = 13;
    localparam int unsigned K_DOWN   = 14;
    localparam int unsigned K_RIGHT  = 15;

    // Bit positions in the game byte and the navigation field.
    localparam int unsigned G_UP     = 0;
    localparam int unsigned G_DOWN   = 1;
    localparam int unsigned G_LEFT   = 2;
    localparam int unsigned G_RIGHT  = 3;
    localparam int unsigned G_A      = 4;
    localparam int unsigned G_B      = 5;
    localparam int unsigned G_START  = 6;
    localparam int unsigned G_SELECT = 7;

    // Bit positions in the action flags.
    localparam int unsigned ACT_SETTINGS = 0;
    localparam int unsigned ACT_ROTATE   = 1;
    localparam int unsigned ACT_REFRESH  = 2;
    localparam int unsigned ACT_DIM      = 3;
    localparam int unsigned ACT_BRIGHTEN = 4;
    localparam int unsigned ACT_LOAD     = 5;
    localparam int unsigned ACT_SAVE     = 6;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [NAV_W-1:0]  nav;
        logic [GAME_W-1:0] game_base;
        logic              turbo_a;
        logic              turbo_b;
    } dec_t;

endpackage

// ===== rtl/gamepad_chord_turbo_decoder.sv =====
// Top level of the gamepad chord and turbo decoder: three-stage pipeline with stream handshakes.
//
//  Channel | Direction | tdata fields (low bit first)
//  s_      | in        | keys_held[15:0], now_ms[47:16]
//  m_      | out       | game_buttons[7:0], nav_buttons[13:8], action_flags[20:14], zero
//
// One request is accepted per cycle unless a stalled result holds the pipeline; each result
// passes the chord, turbo and output registers in that order. Chord latches and turbo start
// times update in the accepting cycle; the turbo slot parity takes a partial-product stage and a sum stage.
// Reset clears the key history, chord latches and turbo start times and empties the pipeline.
// A stalled result holds only the stages that have nowhere to go; bubbles behind it still fill.
module gamepad_chord_turbo_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gctd_pkg::S_TDATA_W-1:0] s_tdata,   // keys_held, now_ms
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gctd_pkg::M_TDATA_W-1:0] m_tdata    // game_buttons, nav_buttons, action_flags
);

    logic accept, adv2, adv3;
    logic v1_reg, v2_reg, m_tvalid_reg;

    gctd_pkg::dec_t              dec1, dec2_reg;
    logic [gctd_pkg::TIME_W-1:0] x_elapsed, y_elapsed;
    logic                        x_on, y_on;
    logic [gctd_pkg::GAME_W-1:0] game;
    logic [gctd_pkg::M_TDATA_W-1:0] m_tdata_reg;

    assign adv3     = ~m_tvalid_reg | m_tready;
    assign adv2     = ~v2_reg | adv3;
    assign s_tready = ~v1_reg | adv2;
    assign accept   = s_tvalid & s_tready;

    gctd_chord u_chord (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .keys_held       (s_tdata[gctd_pkg::MASK_W-1:0]),
        .now_ms          (s_tdata[gctd_pkg::MASK_W +: gctd_pkg::TIME_W]),
        .dec             (dec1),
        .turbo_x_elapsed (x_elapsed),
        .turbo_y_elapsed (y_elapsed)
    );

    gctd_turbo_phase u_turbo_x (
        .aclk     (aclk),
        .load     (adv2 & v1_reg),
        .elapsed  (x_elapsed),
        .turbo_on (x_on)
    );

    gctd_turbo_phase u_turbo_y (
        .aclk     (aclk),
        .load     (adv2 & v1_reg),
        .elapsed  (y_elapsed),
        .turbo_on (y_on)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                v1_reg <= s_tvalid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                m_tvalid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && v1_reg) begin
            dec2_reg <= dec1;
        end
    end

    always_comb begin
        game = dec2_reg.game_base;
        game[gctd_pkg::G_A] = dec2_reg.game_base[gctd_pkg::G_A] | (dec2_reg.turbo_a & x_on);
        game[gctd_pkg::G_B] = dec2_reg.game_base[gctd_pkg::G_B] | (dec2_reg.turbo_b & y_on);
    end

    always_ff @(posedge aclk) begin
        if (adv3 && v2_reg) begin
            m_tdata_reg <= {{gctd_pkg::M_PAD_W{1'b0}}, dec2_reg.act, dec2_reg.nav, game};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/gctd_chord.sv =====
// Chord latches, button history and turbo start times, with the first pipeline register.
`include "gamepad_chord_turbo_decoder_defines.svh"

module gctd_chord (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [gctd_pkg::MASK_W-1:0]   keys_held,
    input  logic [gctd_pkg::TIME_W-1:0]   now_ms,
    output gctd_pkg::dec_t                dec,
    output logic [gctd_pkg::TIME_W-1:0]   turbo_x_elapsed,
    output logic [gctd_pkg::TIME_W-1:0]   turbo_y_elapsed
);

    logic [gctd_pkg::MASK_W-1:0] prev_reg, prev_next;
    logic [gctd_pkg::TIME_W-1:0] x_start_reg, x_start_next;
    logic [gctd_pkg::TIME_W-1:0] y_start_reg, y_start_next;
    logic settings_reg, settings_next;
    logic rotate_reg, rotate_next;
    logic refresh_reg, refresh_next;
    logic select_used_reg, select_used_next;
    logic start_used_reg, start_used_next;

    gctd_pkg::dec_t              dec_reg, dec_next;
    logic [gctd_pkg::TIME_W-1:0] x_elapsed_reg, y_elapsed_reg;

    logic [gctd_pkg::MASK_W-1:0] p, rise;
    logic set_full, set_any, rot_full, rot_any, ref_only, ref_rise;
    logic set_fire, rot_fire, ref_fire;
    logic sh_any, only_l, only_r, sel_used, st_used;

    assign p = keys_held;

    always_comb begin
        rise = p & ~prev_reg;
        set_full = p[gctd_pkg::K_L] & p[gctd_pkg::K_R]
                 & p[gctd_pkg::K_START] & p[gctd_pkg::K_SELECT];
        set_any  = p[gctd_pkg::K_L] | p[gctd_pkg::K_R]
                 | p[gctd_pkg::K_START] | p[gctd_pkg::K_SELECT];
        rot_full = p[gctd_pkg::K_L] & p[gctd_pkg::K_R] & p[gctd_pkg::K_RIGHT];
        rot_any  = p[gctd_pkg::K_L] | p[gctd_pkg::K_R] | p[gctd_pkg::K_RIGHT];
        ref_only = p[gctd_pkg::K_START] & p[gctd_pkg::K_SELECT]
                 & ~p[gctd_pkg::K_L] & ~p[gctd_pkg::K_R];
        ref_rise = rise[gctd_pkg::K_START] | rise[gctd_pkg::K_SELECT];
        sh_any   = p[gctd_pkg::K_L] | p[gctd_pkg::K_R];
        only_l   = p[gctd_pkg::K_L] & ~p[gctd_pkg::K_R];
        only_r   = p[gctd_pkg::K_R] & ~p[gctd_pkg::K_L];

        set_fire = set_full & ~settings_reg;
        rot_fire = rot_full & (~rotate_reg | rise[gctd_pkg::K_RIGHT]);
        ref_fire = ref_only & ref_rise & ~refresh_reg;

        prev_next        = p;
        x_start_next     = x_start_reg;
        y_start_next     = y_start_reg;
        settings_next    = settings_reg;
        rotate_next      = rotate_reg;
        refresh_next     = refresh_reg;
        select_used_next = select_used_reg;
        start_used_next  = start_used_reg;
        sel_used         = 1'b0;
        st_used          = 1'b0;
        dec_next         = '0;

        if (settings_reg || set_fire) begin
            // Settings chord mutes everything until all four keys are let go.
            dec_next.act[gctd_pkg::ACT_SETTINGS] = set_fire;
            if (set_fire) begin
                refresh_next = 1'b0;
            end
            select_used_next = p[gctd_pkg::K_SELECT];
            start_used_next  = p[gctd_pkg::K_START];
            settings_next    = set_any;
        end else if (rotate_reg || rot_fire) begin
            dec_next.act[gctd_pkg::ACT_ROTATE] = rot_fire;
            rotate_next = rot_any;
        end else if (refresh_reg || ref_fire) begin
            dec_next.act[gctd_pkg::ACT_REFRESH] = ref_fire;
            select_used_next = p[gctd_pkg::K_SELECT];
            start_used_next  = p[gctd_pkg::K_START];
            refresh_next     = set_any;
        end else begin
            if (rise[gctd_pkg::K_X]) begin
                x_start_next = now_ms;
            end
            if (rise[gctd_pkg::K_Y]) begin
                y_start_next = now_ms;
            end
            sel_used = p[gctd_pkg::K_SELECT] & select_used_reg;
            st_used  = p[gctd_pkg::K_START] & start_used_reg;
            if (p[gctd_pkg::K_SELECT] && !p[gctd_pkg::K_START] && sh_any) begin
                sel_used = 1'b1;
                dec_next.act[gctd_pkg::ACT_DIM] = only_l
                    & (rise[gctd_pkg::K_L] | rise[gctd_pkg::K_SELECT]);
                dec_next.act[gctd_pkg::ACT_BRIGHTEN] = only_r
                    & (rise[gctd_pkg::K_R] | rise[gctd_pkg::K_SELECT]);
            end else if (p[gctd_pkg::K_START] && !p[gctd_pkg::K_SELECT]) begin
                if (sh_any) begin
                    st_used = 1'b1;
                end
                dec_next.act[gctd_pkg::ACT_LOAD] = only_l
                    & (rise[gctd_pkg::K_L] | rise[gctd_pkg::K_START]);
                dec_next.act[gctd_pkg::ACT_SAVE] = only_r
                    & (rise[gctd_pkg::K_R] | rise[gctd_pkg::K_START]);
            end
            select_used_next = sel_used;
            start_used_next  = st_used;

            dec_next.nav[gctd_pkg::G_UP]    = p[gctd_pkg::K_UP];
            dec_next.nav[gctd_pkg::G_DOWN]  = p[gctd_pkg::K_DOWN];
            dec_next.nav[gctd_pkg::G_LEFT]  = p[gctd_pkg::K_LEFT];
            dec_next.nav[gctd_pkg::G_RIGHT] = p[gctd_pkg::K_RIGHT];
            dec_next.nav[gctd_pkg::G_A]     = p[gctd_pkg::K_A];
            dec_next.nav[gctd_pkg::G_B]     = p[gctd_pkg::K_B];
            dec_next.game_base[gctd_pkg::NAV_W-1:0] = dec_next.nav;
            dec_next.game_base[gctd_pkg::G_START]   = p[gctd_pkg::K_START] & ~st_used;
            dec_next.game_base[gctd_pkg::G_SELECT]  = p[gctd_pkg::K_SELECT] & ~sel_used;
            dec_next.turbo_a = p[gctd_pkg::K_X];
            dec_next.turbo_b = p[gctd_pkg::K_Y];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg        <= '0;
            x_start_reg     <= '0;
            y_start_reg     <= '0;
            settings_reg    <= 1'b0;
            rotate_reg      <= 1'b0;
            refresh_reg     <= 1'b0;
            select_used_reg <= 1'b0;
            start_used_reg  <= 1'b0;
        end else if (accept) begin
            prev_reg        <= prev_next;
            x_start_reg     <= x_start_next;
            y_start_reg     <= y_start_next;
            settings_reg    <= settings_next;
            rotate_reg      <= rotate_next;
            refresh_reg     <= refresh_next;
            select_used_reg <= select_used_next;
            start_used_reg  <= start_used_next;
        end
    end

    // Elapsed times are taken against the start times as this request leaves them.
    always_ff @(posedge aclk) begin
        if (accept) begin
            dec_reg       <= dec_next;
            x_elapsed_reg <= now_ms - x_start_next;
            y_elapsed_reg <= now_ms - y_start_next;
        end
    end

    assign dec             = dec_reg;
    assign turbo_x_elapsed = x_elapsed_reg;
    assign turbo_y_elapsed = y_elapsed_reg;

    `GCTD_ASSERT(settings_refresh_excl, !(settings_reg && refresh_reg))
    `GCTD_ASSERT_NEXT(single_action, accept, $onehot0(dec_reg.act))
    `GCTD_ASSERT_NEXT(settings_mutes, accept && settings_reg,
        dec_reg.nav == '0 && dec_reg.game_base == '0)

endmodule

// ===== rtl/gctd_turbo_phase.sv =====
// Turbo slot parity: elapsed time divided by the half period via a split reciprocal product.
module gctd_turbo_phase (
    input  logic                        aclk,
    input  logic                        load,
    input  logic [gctd_pkg::TIME_W-1:0] elapsed,
    output logic                        turbo_on
);

    localparam int unsigned PP_W = gctd_pkg::RECIP_W + gctd_pkg::HALF_W;

    logic [PP_W-1:0]             pp_lo_reg, pp_hi_reg;
    logic [gctd_pkg::PROD_W-1:0] product;

    // Two half-width partial products, registered before they are summed.
    always_ff @(posedge aclk) begin
        if (load) begin
            pp_lo_reg <= PP_W'(elapsed[gctd_pkg::HALF_W-1:0]) * PP_W'(gctd_pkg::TURBO_RECIP);
            pp_hi_reg <= PP_W'(elapsed[gctd_pkg::TIME_W-1:gctd_pkg::HALF_W])
                       * PP_W'(gctd_pkg::TURBO_RECIP);
        end
    end

    assign product  = (gctd_pkg::PROD_W'(pp_hi_reg) << gctd_pkg::HALF_W)
                    + gctd_pkg::PROD_W'(pp_lo_reg);
    // Even slots counted from the press are the on phase.
    assign turbo_on = ~product[gctd_pkg::TURBO_SHIFT];

endmodule

// ===== tb/sv/tb_gamepad_chord_turbo_decoder.sv =====
// Self-checking testbench for the gamepad chord and turbo decoder stream block.
`timescale 1ns / 100ps

module tb_gamepad_chord_turbo_decoder;
    import gctd_pkg::*;

    localparam int unsigned WATCHDOG_CYCLES = 200000;
    localparam int unsigned SLOT_MS = (TURBO_HALF_MS == 0) ? 1 : TURBO_HALF_MS;

    localparam logic [15:0] KEY_UP     = 16'd1 << K_UP;
    localparam logic [15:0] KEY_LEFT   = 16'd1 << K_LEFT;
    localparam logic [15:0] KEY_X      = 16'd1 << K_X;
    localparam logic [15:0] KEY_A      = 16'd1 << K_A;
    localparam logic [15:0] KEY_Y      = 16'd1 << K_Y;
    localparam logic [15:0] KEY_B      = 16'd1 << K_B;
    localparam logic [15:0] KEY_R      = 16'd1 << K_R;
    localparam logic [15:0] KEY_START  = 16'd1 << K_START;
    localparam logic [15:0] KEY_SELECT = 16'd1 << K_SELECT;
    localparam logic [15:0] KEY_L      = 16'd1 << K_L;
    localparam logic [15:0] KEY_DOWN   = 16'd1 << K_DOWN;
    localparam logic [15:0] KEY_RIGHT  = 16'd1 << K_RIGHT;

    localparam logic [15:0] SHOULDERS     = KEY_L | KEY_R;
    localparam logic [15:0] SET_CHORD     = KEY_L | KEY_R | KEY_START | KEY_SELECT;
    localparam logic [15:0] ROTATE_CHORD  = KEY_L | KEY_R | KEY_RIGHT;
    localparam logic [15:0] REFRESH_CHORD = KEY_START | KEY_SELECT;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [NAV_W-1:0]  nav;
        logic [GAME_W-1:0] game;
    } buttons_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Decoder state as the block should hold it.
    logic [15:0] last_mask     = '0;
    logic [31:0] x_since       = '0;
    logic [31:0] y_since       = '0;
    logic        settings_held = 1'b0;
    logic        rotate_held   = 1'b0;
    logic        refresh_held  = 1'b0;
    logic        select_taken  = 1'b0;
    logic        start_taken   = 1'b0;

    buttons_t    pending_buttons[$];
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    logic        steady      = 1'b0;
    logic [31:0] now_ms      = '0;

    gamepad_chord_turbo_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // keys_held, now_ms
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // game_buttons, nav_buttons, action_flags
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic turbo_phase(input logic [31:0] now, input logic [31:0] since);
        logic [31:0] elapsed;
        elapsed = now - since;
        return ((elapsed / SLOT_MS) & 32'd1) == 32'd0;
    endfunction

    // Advances the decoder state by one request and returns the buttons it should report.
    function automatic buttons_t decode_keys(input logic [15:0] p, input logic [31:0] now);
        logic [15:0] rise;
        logic        muted;
        buttons_t    r;
        rise  = p & ~last_mask;
        muted = 1'b0;
        r     = '0;

        if ((p & SET_CHORD) == SET_CHORD && !settings_held) begin
            settings_held = 1'b1;
            refresh_held  = 1'b0;
            r.act[ACT_SETTINGS] = 1'b1;
        end
        if (settings_held) begin
            select_taken = p[K_SELECT];
            start_taken  = p[K_START];
            if ((p & SET_CHORD) == '0) settings_held = 1'b0;
            muted = 1'b1;
        end

        if (!muted) begin
            if ((p & ROTATE_CHORD) == ROTATE_CHORD && (!rotate_held || rise[K_RIGHT])) begin
                rotate_held = 1'b1;
                r.act[ACT_ROTATE] = 1'b1;
            end
            if (rotate_held) begin
                if ((p & ROTATE_CHORD) == '0) rotate_held = 1'b0;
                muted = 1'b1;
            end
        end

        if (!muted) begin
            if ((p & SET_CHORD) == REFRESH_CHORD && (rise & REFRESH_CHORD) != '0
                    && !refresh_held) begin
                refresh_held = 1'b1;
                r.act[ACT_REFRESH] = 1'b1;
            end
            if (refresh_held) begin
                select_taken = p[K_SELECT];
                start_taken  = p[K_START];
                if ((p & SET_CHORD) == '0) refresh_held = 1'b0;
                muted = 1'b1;
            end
        end

        if (!muted) begin
            if (rise[K_X]) x_since = now;
            if (rise[K_Y]) y_since = now;
            if (!p[K_SELECT]) select_taken = 1'b0;
            if (!p[K_START]) start_taken = 1'b0;
            if ((p & REFRESH_CHORD) != REFRESH_CHORD && p[K_SELECT] && (p & SHOULDERS) != '0) begin
                select_taken = 1'b1;
                if ((p & SHOULDERS) == KEY_L && (rise & (KEY_L | KEY_SELECT)) != '0)
                    r.act[ACT_DIM] = 1'b1;
                if ((p & SHOULDERS) == KEY_R && (rise & (KEY_R | KEY_SELECT)) != '0)
                    r.act[ACT_BRIGHTEN] = 1'b1;
            end else if (p[K_START] && !p[K_SELECT]) begin
                if ((p & SHOULDERS) != '0) start_taken = 1'b1;
                if ((p & SHOULDERS) == KEY_L && (rise & (KEY_L | KEY_START)) != '0)
                    r.act[ACT_LOAD] = 1'b1;
                if ((p & SHOULDERS) == KEY_R && (rise & (KEY_R | KEY_START)) != '0)
                    r.act[ACT_SAVE] = 1'b1;
            end
            r.nav[G_UP]    = p[K_UP];
            r.nav[G_DOWN]  = p[K_DOWN];
            r.nav[G_LEFT]  = p[K_LEFT];
            r.nav[G_RIGHT] = p[K_RIGHT];
            r.nav[G_A]     = p[K_A];
            r.nav[G_B]     = p[K_B];
            r.game = GAME_W'(r.nav);
            if (p[K_X] && turbo_phase(now, x_since)) r.game[G_A] = 1'b1;
            if (p[K_Y] && turbo_phase(now, y_since)) r.game[G_B] = 1'b1;
            if (p[K_START] && !start_taken) r.game[G_START] = 1'b1;
            if (p[K_SELECT] && !select_taken) r.game[G_SELECT] = 1'b1;
        end

        last_mask = p;
        return r;
    endfunction

    // Offers one request, waits for it to be taken and records the buttons it should yield.
    task automatic press_keys(input logic [15:0] mask, input logic [31:0] now);
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, mask};
        do @(posedge aclk); while (!s_tready);
        pending_buttons.push_back(decode_keys(mask, now));
    endtask

    task automatic test_field_extremes();
        press_keys(16'h0000, 32'h0000_0000);
        press_keys(16'hFFFF, 32'hFFFF_FFFF);
        press_keys(16'h0000, 32'h0000_0001);
    endtask

    task automatic test_ui_chords();
        press_keys(SET_CHORD, 32'd100);
        press_keys(SET_CHORD | KEY_UP, 32'd110);       // held chord must not fire again
        press_keys(16'h0000, 32'd120);
        press_keys(ROTATE_CHORD, 32'd130);
        press_keys(SHOULDERS, 32'd140);
        press_keys(ROTATE_CHORD, 32'd150);             // a fresh Right press fires once more
        press_keys(16'h0000, 32'd160);
        press_keys(REFRESH_CHORD, 32'd170);
        press_keys(REFRESH_CHORD | KEY_A, 32'd180);
        press_keys(16'h0000, 32'd190);
    endtask

    task automatic test_shoulder_actions();
        press_keys(KEY_L | KEY_SELECT, 32'd200);
        press_keys(KEY_R | KEY_SELECT, 32'd210);
        press_keys(KEY_START | KEY_L, 32'd220);
        press_keys(16'h0000, 32'd230);
        press_keys(KEY_START | KEY_R | KEY_LEFT, 32'd240);
        press_keys(KEY_START | KEY_B, 32'd250);        // Start stays swallowed after the save
        press_keys(16'h0000, 32'd260);
    endtask

    task automatic test_turbo_slots();
        press_keys(KEY_X | KEY_Y, 32'd1000);
        press_keys(KEY_X | KEY_Y | KEY_DOWN, 32'd1000 + SLOT_MS - 1);
        press_keys(KEY_X | KEY_Y | KEY_RIGHT, 32'd1000 + SLOT_MS);
        press_keys(KEY_X | KEY_Y, 32'd1000 + 2 * SLOT_MS);
        press_keys(16'h0000, 32'd1000 + 2 * SLOT_MS + 1);
    endtask

    // Button sessions: mostly single key changes and whole chords, with some noise.
    task automatic test_random_sessions(input int unsigned count);
        logic [15:0] held;
        logic [15:0] chords[8];
        int unsigned key_pos[12];
        held = '0;
        chords = '{SET_CHORD, ROTATE_CHORD, REFRESH_CHORD, KEY_L | KEY_SELECT,
                   KEY_R | KEY_SELECT, KEY_L | KEY_START, KEY_R | KEY_START, KEY_RIGHT};
        key_pos = '{K_UP, K_LEFT, K_X, K_A, K_Y, K_B, K_R, K_START, K_SELECT, K_L, K_DOWN,
                    K_RIGHT};
        repeat (count) begin
            case ($urandom_range(0, 11))
                0:       held = 16'($urandom);
                1, 2:    held = held | chords[$urandom_range(0, 7)];
                3:       held = held & ~chords[$urandom_range(0, 7)];
                4:       held = '0;
                default: held = held ^ (16'd1 << key_pos[$urandom_range(0, 11)]);
            endcase
            case ($urandom_range(0, 39))
                0:       now_ms = $urandom;
                1:       now_ms = 32'hFFFF_FFC0 + $urandom_range(0, 63);
                default: now_ms = now_ms + $urandom_range(0, 70);
            endcase
            press_keys(held, now_ms);
        end
    endtask

    task automatic test_steady_tail();
        steady = 1'b1;
        test_random_sessions(150);
    endtask

    // The result side stalls in bursts until the closing part of the run.
    initial begin
        forever begin
            @(posedge aclk);
            if (!steady && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_buttons.size() == 0) begin
                $error("result with no request waiting: tdata %h", m_tdata);
                fault_count++;
            end else begin
                buttons_t want;
                want = pending_buttons.pop_front();
                if (m_tdata[7:0] !== want.game) begin
                    $error("game_buttons: expected %h, got %h", want.game, m_tdata[7:0]);
                    fault_count++;
                end
                if (m_tdata[13:8] !== want.nav) begin
                    $error("nav_buttons: expected %h, got %h", want.nav, m_tdata[13:8]);
                    fault_count++;
                end
                if (m_tdata[20:14] !== want.act) begin
                    $error("action_flags: expected %h, got %h", want.act, m_tdata[20:14]);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= WATCHDOG_CYCLES) begin
            $display("[gamepad_chord_turbo_decoder] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_ui_chords();
        test_shoulder_actions();
        test_turbo_slots();
        test_random_sessions(1000);
        test_steady_tail();

        s_tvalid <= 1'b0;
        while (pending_buttons.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fault_count == 0 && pending_buttons.size() == 0) begin
            $display("[gamepad_chord_turbo_decoder] OK");
        end else begin
            $display("[gamepad_chord_turbo_decoder] ERROR");
        end
        $finish;
    end

endmodule
